// File: sv/bdq_pkg.sv
// shared types and codes for the bounded deque with delete
`default_nettype none

package bdq_pkg;

   // request command codes
   typedef enum logic [1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_PUSH_BACK  = 2'd1,
      REQ_DELETE     = 2'd2,
      REQ_NOP        = 2'd3
   } req_cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      RSP_OK        = 2'd0,
      RSP_FULL      = 2'd1,
      RSP_NOT_FOUND = 2'd2
   } rsp_status_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_REJECT_FULL,
      OP_NOP,
      OP_MISS,
      OP_SCAN_START,
      OP_SCAN_STEP,
      OP_SCAN_END
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

// File: sv/bdq_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/bdq_ctrl.sv
// controller state machine: decodes requests and sequences the delete scan
`default_nettype none

module bdq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             req_command,
   input  wire bdq_pkg::dp_status_type dp_stat,
   output bdq_pkg::ctl_cmd_type        cmd,
   output logic                        busy,
   output logic                        rsp_valid
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd.op   = bdq_pkg::OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               valid_in = 1'b1;
               unique case (bdq_pkg::req_cmd_type'(req_command))
                  bdq_pkg::REQ_PUSH_FRONT: begin
                     cmd.op = dp_stat.full ? bdq_pkg::OP_REJECT_FULL : bdq_pkg::OP_PUSH_FRONT;
                  end
                  bdq_pkg::REQ_PUSH_BACK: begin
                     cmd.op = dp_stat.full ? bdq_pkg::OP_REJECT_FULL : bdq_pkg::OP_PUSH_BACK;
                  end
                  bdq_pkg::REQ_DELETE: begin
                     if (dp_stat.empty) begin
                        cmd.op = bdq_pkg::OP_MISS;
                     end else begin
                        cmd.op   = bdq_pkg::OP_SCAN_START;
                        valid_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     cmd.op = bdq_pkg::OP_NOP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (dp_stat.scan_last) begin
               cmd.op   = bdq_pkg::OP_SCAN_END;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.op = bdq_pkg::OP_SCAN_STEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff == S_SCAN);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// File: sv/bdq_datapath.sv
// datapath: ring pointers, entry ram, scan and shift logic, result registers
`default_nettype none

module bdq_datapath #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bdq_pkg::ctl_cmd_type          cmd,
   input  wire logic signed [DATA_WIDTH-1:0]  req_value,
   output bdq_pkg::dp_status_type             dp_stat,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic signed [DATA_WIDTH-1:0]       rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]       rsp_back_value
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

   logic [AW-1:0]         front_pos_ff, front_pos_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_val_ff, front_val_in;
   logic [DATA_WIDTH-1:0] back_val_ff, back_val_in;
   logic [DATA_WIDTH-1:0] kept_ff, kept_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [1:0]            status_ff, status_in;
   logic [CW-1:0]         next_k_ff, next_k_in;
   logic [CW-1:0]         data_idx_ff, data_idx_in;
   logic                  found_ff, found_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic                  hit;
   logic                  removed;

   // ring slot of logical place k
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW:0]   k);
      logic [AW:0] sum;
      sum = {1'b0, base} + k;
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit     = !found_ff && (rd_data == key_ff);
   assign removed = found_ff || hit;

   always_comb begin
      front_pos_in = front_pos_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      kept_in      = kept_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      next_k_in    = next_k_ff;
      data_idx_in  = data_idx_ff;
      found_in     = found_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(front_pos_ff, (AW + 1)'(count_ff));
      wr_data      = req_value;
      rd_en        = 1'b0;
      rd_addr      = slot_of(front_pos_ff, (AW + 1)'(next_k_ff));

      unique case (cmd.op)
         bdq_pkg::OP_PUSH_FRONT: begin
            front_pos_in = (front_pos_ff == '0) ? LAST_POS : front_pos_ff - AW'(1);
            wr_en        = 1'b1;
            wr_addr      = front_pos_in;
            front_val_in = req_value;
            if (count_ff == '0) begin
               back_val_in = req_value;
            end
            count_in  = count_ff + CW'(1);
            status_in = bdq_pkg::RSP_OK;
         end
         bdq_pkg::OP_PUSH_BACK: begin
            wr_en       = 1'b1;
            back_val_in = req_value;
            if (count_ff == '0) begin
               front_val_in = req_value;
            end
            count_in  = count_ff + CW'(1);
            status_in = bdq_pkg::RSP_OK;
         end
         bdq_pkg::OP_REJECT_FULL: begin
            status_in = bdq_pkg::RSP_FULL;
         end
         bdq_pkg::OP_NOP: begin
            status_in = bdq_pkg::RSP_OK;
         end
         bdq_pkg::OP_MISS: begin
            status_in = bdq_pkg::RSP_NOT_FOUND;
         end
         bdq_pkg::OP_SCAN_START: begin
            key_in      = req_value;
            found_in    = 1'b0;
            rd_en       = 1'b1;
            rd_addr     = front_pos_ff;
            data_idx_in = '0;
            next_k_in   = CW'(1);
         end
         bdq_pkg::OP_SCAN_STEP, bdq_pkg::OP_SCAN_END: begin
            // entries after the match move one place toward the front
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(front_pos_ff, (AW + 1)'(data_idx_ff - CW'(1)));
               wr_data = rd_data;
               if (data_idx_ff == CW'(1)) begin
                  front_val_in = rd_data;
               end
            end
            if (!hit) begin
               kept_in = rd_data;
            end
            found_in = removed;
            if (cmd.op == bdq_pkg::OP_SCAN_STEP) begin
               rd_en       = 1'b1;
               next_k_in   = next_k_ff + CW'(1);
               data_idx_in = data_idx_ff + CW'(1);
            end else if (removed) begin
               count_in    = count_ff - CW'(1);
               back_val_in = hit ? kept_ff : rd_data;
               status_in   = bdq_pkg::RSP_OK;
            end else begin
               status_in = bdq_pkg::RSP_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_pos_ff <= '0;
         count_ff     <= '0;
      end else begin
         front_pos_ff <= front_pos_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_val_ff <= front_val_in;
      back_val_ff  <= back_val_in;
      kept_ff      <= kept_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      next_k_ff    <= next_k_in;
      data_idx_ff  <= data_idx_in;
      found_ff     <= found_in;
   end

   assign dp_stat.empty     = (count_ff == '0);
   assign dp_stat.full      = (count_ff == DEPTH_C);
   assign dp_stat.scan_last = (data_idx_ff == count_ff - CW'(1));

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_front_value = (count_ff == '0) ? '0 : front_val_ff;
   assign rsp_back_value  = (count_ff == '0) ? '0 : back_val_ff;

endmodule

`default_nettype wire

// File: sv/bounded_deque_with_delete.sv
// Bounded deque of signed values with push front, push back and delete of the
// first match. An item is taken when start is high and busy is low; its result
// is on the rsp_ ports for exactly one cycle with rsp_valid high, and the
// receiver must capture it then since it cannot stall the block. Pushes, no-ops,
// full pushes and deletes on an empty store finish at the edge that takes them,
// so their result is on the ports in the next cycle and such items can follow
// one per cycle. A delete reads every held entry in turn from the
// single-read-port entry ram, one per cycle, shifting later entries forward as
// it goes: busy stays high until the scan has read every entry held when the
// delete is taken (up to DEPTH), and the result is on the ports in the first
// cycle that busy is low, when the next item can already be taken. The entry
// ram needs no clear after reset.
`default_nettype none

module bounded_deque_with_delete #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_command,
   input  wire logic signed [DATA_WIDTH-1:0]  req_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic signed [DATA_WIDTH-1:0]       rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]       rsp_back_value
);

   bdq_pkg::ctl_cmd_type   cmd;
   bdq_pkg::dp_status_type dp_stat;

   bdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .dp_stat     (dp_stat),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   bdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_value       (req_value),
      .dp_stat         (dp_stat),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

endmodule

`default_nettype wire
